// ----- rtl/utf8_text_can_framer_assert.svh -----
// Assertion macros for the text framer; clocked on clk, disabled in reset.
`ifndef UTF8_TEXT_CAN_FRAMER_ASSERT_SVH
`define UTF8_TEXT_CAN_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define UTCF_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("utcf assertion failed");
`define UTCF_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("utcf assertion failed");
`else
`define UTCF_ASSERT(label, prop)
`define UTCF_ASSERT_NEXT(label, cond, expr)
`endif

`endif

// ----- rtl/utcf_pkg.sv -----
`default_nettype none
package utcf_pkg;
	localparam int CHUNK_BYTES = 7;
	localparam int CNT_W       = $clog2(CHUNK_BYTES + 1);
	localparam int PAYLOAD_W   = 56;
	localparam int LEN_W       = 3;
	localparam int FID_W       = 11;
	localparam int CFG_W       = 11;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_TEXT  = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	localparam logic REG_ENABLE   = 1'b0;
	localparam logic REG_FRAME_ID = 1'b1;

	localparam logic [7:0] CMD_CLEAR = 8'h3f;
	localparam logic [7:0] CMD_ROW0  = 8'h30;
	localparam logic [7:0] CMD_CONT  = 8'h32;

	localparam logic [FID_W-1:0] FRAME_ID_RESET = 11'd768;

	typedef struct packed {
		logic load;
		logic take_new;
	} cell_ctl_t;

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/utcf_if.sv -----
`default_nettype none
interface utcf_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic       row;
	logic [7:0] text_byte;

	modport source (output valid, operation, row, text_byte, input ready);
	modport sink   (input valid, operation, row, text_byte, output ready);
endinterface

interface utcf_frame_if;
	logic                           valid;
	logic                           ready;
	logic [utcf_pkg::FID_W-1:0]     frame_id;
	logic [7:0]                     command;
	logic [utcf_pkg::PAYLOAD_W-1:0] payload;
	logic [utcf_pkg::LEN_W-1:0]     payload_length;
	logic                           last;

	modport source (output valid, frame_id, command, payload, payload_length, last,
		input ready);
	modport sink   (input valid, frame_id, command, payload, payload_length, last,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/utcf_cell.sv -----
`default_nettype none
module utcf_cell (
	input  wire logic               clk,
	input  wire utcf_pkg::cell_ctl_t ctl,
	input  wire logic [7:0]         new_byte,
	input  wire logic [7:0]         shift_byte,
	output logic [7:0]              data,
	output logic                    cont
);
	logic [7:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= ctl.take_new ? new_byte : shift_byte;
		end
	end

	assign data = data_q;
	assign cont = utcf_pkg::is_cont(data_q);
endmodule
`default_nettype wire

// ----- rtl/utf8_text_can_framer.sv -----
// Text row framer for a CAN character display.
// item channel: one transfer per operation (page clear, text byte, end of row).
// frame channel: one eight-byte frame per transfer: command byte, up to seven
// text bytes (first byte in payload[7:0]), zero padded, plus its length.
// Text bytes fill a row of seven byte cells; a frame leaves when an eighth
// byte arrives, cut before the last UTF-8 lead byte if the new byte is a
// continuation, with the cut tail shifted down through the cells.
// A frame appears on the frame channel in the cycle after the item transfer
// that causes it. One item per cycle when not stalled, set by the single
// output register; the cut pick and cell shift finish within the transfer cycle.
// The item channel stalls only while a frame waits in the output register
// and the receiver holds ready low.
// Configuration: cfg_we with cfg_index 0 (output enable) or 1 (frame id).
// With output enable low the state still advances but no frame is sent.
// Reset clears the buffer count, the row mark and the output valid; output
// enable resets to 0, frame id to 768.
`default_nettype none
`include "utf8_text_can_framer_assert.svh"
module utf8_text_can_framer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [utcf_pkg::CFG_W-1:0]    cfg_data,
	utcf_item_if.sink                          item,
	utcf_frame_if.source                       frame
);
	localparam int N = utcf_pkg::CHUNK_BYTES;
	localparam int CW = utcf_pkg::CNT_W;

	logic                       en_q;
	logic [utcf_pkg::FID_W-1:0] fid_q;
	logic [CW-1:0]              count_q;
	logic                       row_started_q;

	logic                         out_v_q;
	logic [utcf_pkg::FID_W-1:0]   fid_s1;
	logic [7:0]                   cmd_s1;
	logic [utcf_pkg::PAYLOAD_W-1:0] payload_s1;
	logic [utcf_pkg::LEN_W-1:0]   len_s1;

	logic [7:0]          cell_byte [N];
	logic                cell_cont [N];
	logic [7:0]          shift_src [N];
	utcf_pkg::cell_ctl_t cell_ctl [N];

	logic          fire, text_fire, full, emit;
	logic [CW-1:0] cut, tail, n_out;
	logic [7:0]    cmd_row, cmd_next;
	logic [utcf_pkg::PAYLOAD_W-1:0] payload_next;

	assign item.ready = !out_v_q || frame.ready;
	assign fire       = item.valid && item.ready;
	assign text_fire  = fire && item.operation == utcf_pkg::OP_TEXT;
	assign full       = count_q == CW'(N);

	always_comb begin
		cut = CW'(N);
		if (utcf_pkg::is_cont(item.text_byte)) begin
			for (int p = 1; p < N; p++) begin
				if (!cell_cont[p]) begin
					cut = CW'(p);
				end
			end
		end
	end
	assign tail = CW'(N) - cut;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			shift_src[i] = cell_byte[i];
			for (int c = 1; c < N; c++) begin
				if (i + c < N && cut == CW'(c)) begin
					shift_src[i] = cell_byte[i + c];
				end
			end
			if (full) begin
				cell_ctl[i].load     = text_fire && CW'(i) <= tail;
				cell_ctl[i].take_new = CW'(i) == tail;
			end else begin
				cell_ctl[i].load     = text_fire && CW'(i) == count_q;
				cell_ctl[i].take_new = 1'b1;
			end
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		utcf_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[g]),
			.new_byte  (item.text_byte),
			.shift_byte(shift_src[g]),
			.data      (cell_byte[g]),
			.cont      (cell_cont[g])
		);
	end

	assign cmd_row = row_started_q ? utcf_pkg::CMD_CONT
		: utcf_pkg::CMD_ROW0 + {7'd0, item.row};

	always_comb begin
		unique case (item.operation)
			utcf_pkg::OP_CLEAR: begin
				n_out    = '0;
				cmd_next = utcf_pkg::CMD_CLEAR;
				emit     = 1'b1;
			end
			utcf_pkg::OP_TEXT: begin
				n_out    = cut;
				cmd_next = cmd_row;
				emit     = full;
			end
			utcf_pkg::OP_END: begin
				n_out    = count_q;
				cmd_next = cmd_row;
				emit     = 1'b1;
			end
			default: begin
				n_out    = '0;
				cmd_next = cmd_row;
				emit     = 1'b0;
			end
		endcase
	end

	always_comb begin
		payload_next = '0;
		for (int i = 0; i < N; i++) begin
			if (CW'(i) < n_out) begin
				payload_next[8*i +: 8] = cell_byte[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			fid_q <= utcf_pkg::FRAME_ID_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				utcf_pkg::REG_ENABLE:   en_q  <= cfg_data[0];
				utcf_pkg::REG_FRAME_ID: fid_q <= cfg_data[utcf_pkg::FID_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			row_started_q <= 1'b0;
		end else if (fire) begin
			if (item.operation == utcf_pkg::OP_CLEAR || item.operation == utcf_pkg::OP_END)
			begin
				count_q       <= '0;
				row_started_q <= 1'b0;
			end else if (item.operation == utcf_pkg::OP_TEXT) begin
				if (full) begin
					count_q       <= tail + CW'(1);
					row_started_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fire && emit && en_q) begin
			out_v_q <= 1'b1;
		end else if (frame.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit && en_q) begin
			fid_s1     <= fid_q;
			cmd_s1     <= cmd_next;
			payload_s1 <= payload_next;
			len_s1     <= utcf_pkg::LEN_W'(n_out);
		end
	end

	assign frame.valid          = out_v_q;
	assign frame.frame_id       = fid_s1;
	assign frame.command        = cmd_s1;
	assign frame.payload        = payload_s1;
	assign frame.payload_length = len_s1;
	assign frame.last           = 1'b1;

	`UTCF_ASSERT(a_count_range, count_q <= CW'(N))
	`UTCF_ASSERT(a_stall_only_on_held_frame, !item.ready |-> frame.valid)
	`UTCF_ASSERT_NEXT(a_full_text_emits, text_fire && full && en_q, frame.valid)
	`UTCF_ASSERT_NEXT(a_end_clears,
		fire && (item.operation == utcf_pkg::OP_END || item.operation == utcf_pkg::OP_CLEAR),
		count_q == '0 && !row_started_q)
endmodule
`default_nettype wire
